@@ hdl/lcm_pkg.sv @@
// ----------------------------------------------------------------------------
// lcm_pkg
// Shared widths, defaults, register indexes, command codes and types of the
// letterbox coordinate mapper.
// ----------------------------------------------------------------------------
package lcm_pkg;

    localparam int COORD_W       = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int OUT_X_W       = 12;
    localparam int OUT_Y_W       = 11;
    localparam int FRAME_W_OUT_W = 12;
    localparam int SAFE_LEFT_W   = 11;

    localparam int FRAME_HEIGHT_DEF   = 1080;
    localparam int DEFAULT_WIDTH_DEF  = 1920;
    localparam int CLASSIC_WIDTH_DEF  = 640;
    localparam int CLASSIC_HEIGHT_DEF = 480;

    localparam int WINDOW_WIDTH_RST  = 1920;
    localparam int WINDOW_HEIGHT_RST = 1080;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_WIDTH,
        REG_WINDOW_HEIGHT
    } lcm_reg_t;

    typedef enum logic {
        CMD_TO_PRES,
        CMD_TO_CLASSIC
    } lcm_cmd_t;

    typedef enum logic [2:0] {
        SETUP_START,
        SETUP_DIV_FW,
        SETUP_FIT,
        SETUP_SW_GO,
        SETUP_SW_WAIT,
        SETUP_SH_GO,
        SETUP_SH_WAIT,
        SETUP_READY
    } lcm_setup_state_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } lcm_stage_en_t;

endpackage

@@ hdl/lcm_in_if.sv @@
// ----------------------------------------------------------------------------
// lcm_in_if
// Request channel: command and coordinate pair with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcm_in_if;

    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [lcm_pkg::COORD_W-1:0]  coord_x;
    logic signed [lcm_pkg::COORD_W-1:0]  coord_y;

    modport source (output valid, output cmd, output coord_x, output coord_y, input ready);
    modport sink   (input valid, input cmd, input coord_x, input coord_y, output ready);

endinterface

@@ hdl/lcm_out_if.sv @@
// ----------------------------------------------------------------------------
// lcm_out_if
// Result channel: mapped coordinate, inside flag and frame geometry.
// ----------------------------------------------------------------------------
interface lcm_out_if;

    logic                                   valid;
    logic                                   ready;
    logic [lcm_pkg::OUT_X_W-1:0]            out_x;
    logic [lcm_pkg::OUT_Y_W-1:0]            out_y;
    logic                                   inside_res;
    logic [lcm_pkg::FRAME_W_OUT_W-1:0]      frame_width;
    logic [lcm_pkg::SAFE_LEFT_W-1:0]        safe_left;

    modport source (output valid, output out_x, output out_y, output inside_res,
                    output frame_width, output safe_left, input ready);
    modport sink   (input valid, input out_x, input out_y, input inside_res,
                    input frame_width, input safe_left, output ready);

endinterface

@@ hdl/letterbox_coordinate_mapper_core.sv @@
// ----------------------------------------------------------------------------
// letterbox_coordinate_mapper_core: one item per cycle when result.ready is
// high and frame setup is done. Reset empties the pipeline, loads window size
// 1920x1080 and runs frame setup (three bit-serial divisions) with request.ready
// low; each register write reruns that setup.
// ----------------------------------------------------------------------------
module letterbox_coordinate_mapper_core #(
    parameter int FRAME_HEIGHT   = lcm_pkg::FRAME_HEIGHT_DEF,
    parameter int DEFAULT_WIDTH  = lcm_pkg::DEFAULT_WIDTH_DEF,
    parameter int CLASSIC_WIDTH  = lcm_pkg::CLASSIC_WIDTH_DEF,
    parameter int CLASSIC_HEIGHT = lcm_pkg::CLASSIC_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lcm_in_if.sink                          request,
    lcm_out_if.source                       result,
    input  logic                            wr_en,
    input  logic [lcm_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [lcm_pkg::CFG_W-1:0]       wr_data
);

    localparam int MIN_W    = (4 * FRAME_HEIGHT) / 3;
    localparam int MAX_W    = (32 * FRAME_HEIGHT) / 9;
    localparam int FW_MAX   = (DEFAULT_WIDTH > MAX_W) ? DEFAULT_WIDTH : MAX_W;
    localparam int FW_W     = $clog2(FW_MAX + 1);
    localparam int C_MAX    = (CLASSIC_WIDTH > CLASSIC_HEIGHT) ? CLASSIC_WIDTH : CLASSIC_HEIGHT;
    localparam int N_W      = $clog2(2 * C_MAX * FW_MAX + 1);
    localparam int W_LOW    = (DEFAULT_WIDTH < MIN_W) ? DEFAULT_WIDTH : MIN_W;
    localparam int SH_LOW   = (W_LOW * 3) / 4;
    localparam int SIZE_MIN = (FRAME_HEIGHT < SH_LOW) ? FRAME_HEIGHT : SH_LOW;
    localparam int C_MIN    = (CLASSIC_WIDTH < CLASSIC_HEIGHT) ? CLASSIC_WIDTH : CLASSIC_HEIGHT;
    localparam int D_MIN    = (SIZE_MIN < 2 * C_MIN) ? SIZE_MIN : 2 * C_MIN;
    localparam int R_W      = $clog2((2 ** N_W) / D_MIN + 1);
    localparam int CLS_W    = $clog2(C_MAX + 1);
    localparam int RES_W    = ((CLS_W > FW_W) ? CLS_W : FW_W) + 1;
    localparam int X_LIM    = (FW_MAX > CLASSIC_WIDTH) ? FW_MAX : CLASSIC_WIDTH;
    localparam int Y_LIM    = (FRAME_HEIGHT > CLASSIC_HEIGHT) ? FRAME_HEIGHT : CLASSIC_HEIGHT;

    logic                   setup_ready;
    logic [FW_W-1:0]        fw;
    logic [FW_W-1:0]        sx;
    logic [FW_W-1:0]        sw;
    logic [FW_W-1:0]        sy;
    logic [FW_W-1:0]        sh;
    logic [R_W-1:0]         rw;
    logic [R_W-1:0]         rh;

    lcm_pkg::lcm_stage_en_t ld;
    logic [4:0]             v_reg;
    logic                   take;
    logic [RES_W-1:0]       res_x;
    logic [RES_W-1:0]       res_y;
    logic                   ins_x;
    logic                   ins_y;

    lcm_frame_setup #(
        .FRAME_HEIGHT  (FRAME_HEIGHT),
        .DEFAULT_WIDTH (DEFAULT_WIDTH),
        .FW_W          (FW_W),
        .N_W           (N_W),
        .R_W           (R_W)
    ) u_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .ready    (setup_ready),
        .fw       (fw),
        .sx       (sx),
        .sw       (sw),
        .sy       (sy),
        .sh       (sh),
        .rw       (rw),
        .rh       (rh)
    );

    lcm_axis_pipe #(
        .CLASSIC (CLASSIC_WIDTH),
        .SZ_W    (FW_W),
        .N_W     (N_W),
        .R_W     (R_W),
        .RES_W   (RES_W)
    ) u_axis_x (
        .clk     (clk),
        .en      (ld),
        .cmd     (request.cmd),
        .coord   (request.coord_x),
        .origin  (sx),
        .size    (sw),
        .recip   (rw),
        .res     (res_x),
        .in_safe (ins_x)
    );

    lcm_axis_pipe #(
        .CLASSIC (CLASSIC_HEIGHT),
        .SZ_W    (FW_W),
        .N_W     (N_W),
        .R_W     (R_W),
        .RES_W   (RES_W)
    ) u_axis_y (
        .clk     (clk),
        .en      (ld),
        .cmd     (request.cmd),
        .coord   (request.coord_y),
        .origin  (sy),
        .size    (sh),
        .recip   (rh),
        .res     (res_y),
        .in_safe (ins_y)
    );

    // advance a stage when it is empty or the next one takes its item
    always_comb
    begin
        ld.s5 = !v_reg[4] || result.ready;
        ld.s4 = !v_reg[3] || ld.s5;
        ld.s3 = !v_reg[2] || ld.s4;
        ld.s2 = !v_reg[1] || ld.s3;
        ld.s1 = !v_reg[0] || ld.s2;
        take  = request.valid && request.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld.s1)
            begin
                v_reg[0] <= take;
            end
            if (ld.s2)
            begin
                v_reg[1] <= v_reg[0];
            end
            if (ld.s3)
            begin
                v_reg[2] <= v_reg[1];
            end
            if (ld.s4)
            begin
                v_reg[3] <= v_reg[2];
            end
            if (ld.s5)
            begin
                v_reg[4] <= v_reg[3];
            end
        end
    end

    assign request.ready      = ld.s1 && setup_ready;
    assign result.valid       = v_reg[4];
    assign result.out_x       = (lcm_pkg::OUT_X_W)'(res_x);
    assign result.out_y       = (lcm_pkg::OUT_Y_W)'(res_y);
    assign result.inside_res  = ins_x && ins_y;
    assign result.frame_width = (lcm_pkg::FRAME_W_OUT_W)'(fw);
    assign result.safe_left   = (lcm_pkg::SAFE_LEFT_W)'(sx);

`ifndef SYNTHESIS
    a_safe_fits: assert property (@(posedge clk) disable iff (!rst_n)
        setup_ready |-> ((int'(sx) * 2 + int'(sw) <= int'(fw))
                         && (int'(sy) * 2 + int'(sh) <= FRAME_HEIGHT)))
        else $error("safe rectangle exceeds frame");

    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((int'(res_x) < X_LIM) && (int'(res_y) < Y_LIM)))
        else $error("mapped coordinate out of range");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && !v_reg[3]) |=> !result.valid)
        else $error("result repeated after being taken");
`endif

endmodule

@@ hdl/lcm_divider.sv @@
// ----------------------------------------------------------------------------
// lcm_divider
// Iterative restoring divider, one quotient bit per cycle, done pulse after
// the last bit. A start restarts it at any time.
// ----------------------------------------------------------------------------
module lcm_divider #(
    parameter int N_W = 27,
    parameter int D_W = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic [N_W-1:0] quot,
    output logic           done
);

    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic             active_reg;
    logic             active_next;
    logic             done_reg;
    logic             done_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [D_W-1:0]   den_reg;
    logic [D_W-1:0]   den_next;
    logic [D_W:0]     rem_reg;
    logic [D_W:0]     rem_next;
    logic [N_W-1:0]   quot_reg;
    logic [N_W-1:0]   quot_next;
    logic [D_W:0]     rem_sh;
    logic             ge;

    always_comb
    begin
        rem_sh      = {rem_reg[D_W-1:0], quot_reg[N_W-1]};
        ge          = (rem_sh >= {1'b0, den_reg});
        active_next = active_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quot_next   = quot_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = CNT_W'(N_W - 1);
            den_next    = den;
            rem_next    = '0;
            quot_next   = num;
        end
        else if (active_reg)
        begin
            rem_next  = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quot_next = {quot_reg[N_W-2:0], ge};
            if (cnt_reg == '0)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

@@ hdl/lcm_frame_setup.sv @@
// ----------------------------------------------------------------------------
// lcm_frame_setup
// Window size registers and the sequencer that derives frame width, safe
// rectangle and the reciprocals of the safe rectangle size.
// ----------------------------------------------------------------------------
module lcm_frame_setup #(
    parameter int FRAME_HEIGHT  = lcm_pkg::FRAME_HEIGHT_DEF,
    parameter int DEFAULT_WIDTH = lcm_pkg::DEFAULT_WIDTH_DEF,
    parameter int FW_W          = 12,
    parameter int N_W           = 23,
    parameter int R_W           = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [lcm_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [lcm_pkg::CFG_W-1:0]       wr_data,
    output logic                            ready,
    output logic [FW_W-1:0]                 fw,
    output logic [FW_W-1:0]                 sx,
    output logic [FW_W-1:0]                 sw,
    output logic [FW_W-1:0]                 sy,
    output logic [FW_W-1:0]                 sh,
    output logic [R_W-1:0]                  rw,
    output logic [R_W-1:0]                  rh
);

    localparam int CFG_W   = lcm_pkg::CFG_W;
    localparam int MIN_W   = (4 * FRAME_HEIGHT) / 3;
    localparam int MAX_W   = (32 * FRAME_HEIGHT) / 9;
    localparam int NUMF_W  = $clog2(FRAME_HEIGHT * (2 ** CFG_W - 1) + 2 ** (CFG_W - 1));
    localparam int DIV_N_W = (NUMF_W > N_W + 1) ? NUMF_W : N_W + 1;
    localparam int DIV_D_W = (CFG_W > FW_W) ? CFG_W : FW_W;

    lcm_pkg::lcm_setup_state_t state_reg;
    lcm_pkg::lcm_setup_state_t state_next;

    logic [CFG_W-1:0]   ww_reg;
    logic [CFG_W-1:0]   wh_reg;
    logic [FW_W-1:0]    fw_reg;
    logic [FW_W-1:0]    fw_next;
    logic [FW_W-1:0]    sx_reg;
    logic [FW_W-1:0]    sx_next;
    logic [FW_W-1:0]    sw_reg;
    logic [FW_W-1:0]    sw_next;
    logic [FW_W-1:0]    sy_reg;
    logic [FW_W-1:0]    sy_next;
    logic [FW_W-1:0]    sh_reg;
    logic [FW_W-1:0]    sh_next;
    logic [R_W-1:0]     rw_reg;
    logic [R_W-1:0]     rw_next;
    logic [R_W-1:0]     rh_reg;
    logic [R_W-1:0]     rh_next;

    logic               div_start;
    logic [DIV_N_W-1:0] div_num;
    logic [DIV_D_W-1:0] div_den;
    logic [DIV_N_W-1:0] div_quot;
    logic               div_done;

    logic [DIV_N_W-1:0] fw_num;
    logic [DIV_N_W-1:0] q_even;
    logic [FW_W-1:0]    fw_clamped;
    logic [FW_W+1:0]    fw3;
    logic [FW_W-1:0]    sh_fit;

    lcm_divider #(
        .N_W (DIV_N_W),
        .D_W (DIV_D_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .done  (div_done)
    );

    always_comb
    begin
        fw_num = DIV_N_W'(FRAME_HEIGHT) * DIV_N_W'(ww_reg) + DIV_N_W'(wh_reg >> 1);
        q_even = {div_quot[DIV_N_W-1:1], 1'b0};
        if (q_even < DIV_N_W'(MIN_W))
        begin
            fw_clamped = FW_W'(MIN_W);
        end
        else if (q_even > DIV_N_W'(MAX_W))
        begin
            fw_clamped = FW_W'(MAX_W);
        end
        else
        begin
            fw_clamped = FW_W'(q_even);
        end
        fw3    = {2'b00, fw_reg} + {1'b0, fw_reg, 1'b0};
        sh_fit = FW_W'(fw3 >> 2);
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        fw_next    = fw_reg;
        sx_next    = sx_reg;
        sw_next    = sw_reg;
        sy_next    = sy_reg;
        sh_next    = sh_reg;
        rw_next    = rw_reg;
        rh_next    = rh_reg;
        case (state_reg)
            lcm_pkg::SETUP_START:
            begin
                if ((ww_reg == '0) || (wh_reg == '0))
                begin
                    fw_next    = FW_W'(DEFAULT_WIDTH);
                    state_next = lcm_pkg::SETUP_FIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = fw_num;
                    div_den    = DIV_D_W'(wh_reg);
                    state_next = lcm_pkg::SETUP_DIV_FW;
                end
            end
            lcm_pkg::SETUP_DIV_FW:
            begin
                if (div_done)
                begin
                    fw_next    = fw_clamped;
                    state_next = lcm_pkg::SETUP_FIT;
                end
            end
            lcm_pkg::SETUP_FIT:
            begin
                if (fw3 > (FW_W + 2)'(4 * FRAME_HEIGHT))
                begin
                    sw_next = FW_W'(MIN_W);
                    sx_next = (fw_reg - FW_W'(MIN_W)) >> 1;
                    sh_next = FW_W'(FRAME_HEIGHT);
                    sy_next = '0;
                end
                else
                begin
                    sw_next = fw_reg;
                    sx_next = '0;
                    sh_next = sh_fit;
                    sy_next = (FW_W'(FRAME_HEIGHT) - sh_fit) >> 1;
                end
                state_next = lcm_pkg::SETUP_SW_GO;
            end
            lcm_pkg::SETUP_SW_GO:
            begin
                div_start  = 1'b1;
                div_num    = DIV_N_W'(1) << N_W;
                div_den    = DIV_D_W'(sw_reg);
                state_next = lcm_pkg::SETUP_SW_WAIT;
            end
            lcm_pkg::SETUP_SW_WAIT:
            begin
                if (div_done)
                begin
                    rw_next    = R_W'(div_quot);
                    state_next = lcm_pkg::SETUP_SH_GO;
                end
            end
            lcm_pkg::SETUP_SH_GO:
            begin
                div_start  = 1'b1;
                div_num    = DIV_N_W'(1) << N_W;
                div_den    = DIV_D_W'(sh_reg);
                state_next = lcm_pkg::SETUP_SH_WAIT;
            end
            lcm_pkg::SETUP_SH_WAIT:
            begin
                if (div_done)
                begin
                    rh_next    = R_W'(div_quot);
                    state_next = lcm_pkg::SETUP_READY;
                end
            end
            lcm_pkg::SETUP_READY:
            begin
                state_next = lcm_pkg::SETUP_READY;
            end
            default:
            begin
                state_next = lcm_pkg::SETUP_START;
            end
        endcase
        if (wr_en)
        begin
            state_next = lcm_pkg::SETUP_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcm_pkg::SETUP_START;
            ww_reg    <= CFG_W'(lcm_pkg::WINDOW_WIDTH_RST);
            wh_reg    <= CFG_W'(lcm_pkg::WINDOW_HEIGHT_RST);
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en && (wr_index == lcm_pkg::REG_WINDOW_WIDTH))
            begin
                ww_reg <= wr_data;
            end
            if (wr_en && (wr_index == lcm_pkg::REG_WINDOW_HEIGHT))
            begin
                wh_reg <= wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fw_reg <= fw_next;
        sx_reg <= sx_next;
        sw_reg <= sw_next;
        sy_reg <= sy_next;
        sh_reg <= sh_next;
        rw_reg <= rw_next;
        rh_reg <= rh_next;
    end

    assign ready = (state_reg == lcm_pkg::SETUP_READY);
    assign fw    = fw_reg;
    assign sx    = sx_reg;
    assign sw    = sw_reg;
    assign sy    = sy_reg;
    assign sh    = sh_reg;
    assign rw    = rw_reg;
    assign rh    = rh_reg;

endmodule

@@ hdl/lcm_axis_pipe.sv @@
// ----------------------------------------------------------------------------
// lcm_axis_pipe
// Five-stage datapath for one axis: clamp and operand select, product,
// reciprocal multiply, back multiply, remainder correction and offset.
// ----------------------------------------------------------------------------
module lcm_axis_pipe #(
    parameter int CLASSIC = lcm_pkg::CLASSIC_WIDTH_DEF,
    parameter int SZ_W    = 12,
    parameter int N_W     = 23,
    parameter int R_W     = 14,
    parameter int RES_W   = 13
) (
    input  logic                                clk,
    input  lcm_pkg::lcm_stage_en_t              en,
    input  logic                                cmd,
    input  logic signed [lcm_pkg::COORD_W-1:0]  coord,
    input  logic [SZ_W-1:0]                     origin,
    input  logic [SZ_W-1:0]                     size,
    input  logic [R_W-1:0]                      recip,
    output logic [RES_W-1:0]                    res,
    output logic                                in_safe
);

    localparam int COORD_W = lcm_pkg::COORD_W;
    localparam int CLS_W   = $clog2(CLASSIC + 1);
    localparam int CA_W    = $clog2(2 * CLASSIC);
    localparam int CL_W    = CA_W - 1;
    localparam int OPA_W   = (CA_W > SZ_W) ? CA_W : SZ_W;
    localparam int OPB_W   = (CLS_W > SZ_W) ? CLS_W : SZ_W;
    localparam int Q_W     = (CLS_W > SZ_W) ? CLS_W : SZ_W;
    localparam int DV_W    = (CLS_W + 1 > SZ_W) ? CLS_W + 1 : SZ_W;
    localparam int CMP_A   = (COORD_W > SZ_W + 1) ? COORD_W : SZ_W + 1;
    localparam int CMP_W   = ((CMP_A > CLS_W) ? CMP_A : CLS_W) + 1;
    localparam int RECIP_CLS = (2 ** N_W) / (2 * CLASSIC);
    localparam logic signed [CMP_W-1:0] CLS_MAX_S = CMP_W'(CLASSIC - 1);

    logic signed [CMP_W-1:0] coord_s;
    logic signed [CMP_W-1:0] org_s;
    logic signed [CMP_W-1:0] end_s;
    logic signed [CMP_W-1:0] diff_s;
    logic [CL_W-1:0]         cls_c;
    logic [SZ_W-1:0]         off;
    logic [OPA_W-1:0]        a1_next;
    logic [OPB_W-1:0]        b1_next;
    logic                    in1_next;

    logic                    cmd1_reg;
    logic [OPA_W-1:0]        a1_reg;
    logic [OPB_W-1:0]        b1_reg;
    logic                    in1_reg;

    logic [OPA_W+OPB_W-1:0]  prod2;
    logic                    cmd2_reg;
    logic [N_W-1:0]          n2_reg;
    logic                    in2_reg;

    logic [R_W-1:0]          recip_sel;
    logic [N_W+R_W-1:0]      prod3;
    logic                    cmd3_reg;
    logic [N_W-1:0]          n3_reg;
    logic [Q_W-1:0]          q3_reg;
    logic                    in3_reg;

    logic [DV_W-1:0]         dv_next;
    logic [Q_W+DV_W-1:0]     prod4;
    logic                    cmd4_reg;
    logic [N_W-1:0]          n4_reg;
    logic [Q_W-1:0]          q4_reg;
    logic [N_W-1:0]          t4_reg;
    logic [DV_W-1:0]         dv4_reg;
    logic                    in4_reg;

    logic [N_W-1:0]          rem5;
    logic [Q_W-1:0]          q_fix;
    logic [RES_W-1:0]        res_next;
    logic [RES_W-1:0]        res_reg;
    logic                    in5_reg;

    always_comb
    begin
        coord_s = CMP_W'(coord);
        org_s   = $signed(CMP_W'(origin));
        end_s   = org_s + $signed(CMP_W'(size));
        diff_s  = coord_s - org_s;
        if (coord_s < 0)
        begin
            cls_c = '0;
        end
        else if (coord_s > CLS_MAX_S)
        begin
            cls_c = CL_W'(CLASSIC - 1);
        end
        else
        begin
            cls_c = CL_W'(coord_s);
        end
        if (diff_s < 0)
        begin
            off = '0;
        end
        else if (coord_s >= end_s)
        begin
            off = size - 1'b1;
        end
        else
        begin
            off = SZ_W'(diff_s);
        end
        if (cmd == lcm_pkg::CMD_TO_CLASSIC)
        begin
            a1_next  = OPA_W'(off);
            b1_next  = OPB_W'(CLASSIC);
            in1_next = (coord_s >= org_s) && (coord_s < end_s);
        end
        else
        begin
            a1_next  = OPA_W'({cls_c, 1'b1});
            b1_next  = OPB_W'(size);
            in1_next = 1'b1;
        end
    end

    always_comb
    begin
        prod2     = a1_reg * b1_reg;
        recip_sel = (cmd2_reg == lcm_pkg::CMD_TO_CLASSIC) ? recip : R_W'(RECIP_CLS);
        prod3     = n2_reg * recip_sel;
        dv_next   = (cmd3_reg == lcm_pkg::CMD_TO_CLASSIC) ? DV_W'(size) : DV_W'(2 * CLASSIC);
        prod4     = q3_reg * dv_next;
        rem5      = n4_reg - t4_reg;
        q_fix     = q4_reg + Q_W'(rem5 >= N_W'(dv4_reg));
        res_next  = ((cmd4_reg == lcm_pkg::CMD_TO_CLASSIC) ? RES_W'(0) : RES_W'(origin))
                    + RES_W'(q_fix);
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            cmd1_reg <= cmd;
            a1_reg   <= a1_next;
            b1_reg   <= b1_next;
            in1_reg  <= in1_next;
        end
        if (en.s2)
        begin
            cmd2_reg <= cmd1_reg;
            n2_reg   <= N_W'(prod2);
            in2_reg  <= in1_reg;
        end
        if (en.s3)
        begin
            cmd3_reg <= cmd2_reg;
            n3_reg   <= n2_reg;
            q3_reg   <= Q_W'(prod3 >> N_W);
            in3_reg  <= in2_reg;
        end
        if (en.s4)
        begin
            cmd4_reg <= cmd3_reg;
            n4_reg   <= n3_reg;
            q4_reg   <= q3_reg;
            t4_reg   <= N_W'(prod4);
            dv4_reg  <= dv_next;
            in4_reg  <= in3_reg;
        end
        if (en.s5)
        begin
            res_reg <= res_next;
            in5_reg <= in4_reg;
        end
    end

    assign res     = res_reg;
    assign in_safe = in5_reg;

endmodule
